>>> sv/hpdd_pkg.sv
package hpdd_pkg;

  // Field and register types
  typedef logic signed [15:0] heading_t;   // Q3.12 angle
  typedef logic signed [16:0] err_t;       // Q.12 heading error
  typedef logic signed [17:0] deriv_t;     // error minus previous error
  typedef logic signed [20:0] esum_t;      // clamped error sum, Q.12
  typedef logic signed [21:0] esum_wide_t; // error sum before clamping
  typedef logic [29:0]        gain_t;      // unsigned Q16.14
  typedef logic [14:0]        ulim_t;      // 15-bit unsigned register field
  typedef logic [14:0]        mag_t;       // drive magnitude, Q7.8
  typedef logic signed [15:0] drive_t;     // signed Q7.8 drive
  typedef logic signed [17:0] drive_wide_t;
  typedef logic signed [47:0] prod_p_t;    // gain * error
  typedef logic signed [51:0] prod_i_t;    // gain * error sum
  typedef logic signed [48:0] prod_d_t;    // gain * derivative
  typedef logic signed [53:0] acc_t;       // PID sum, Q.26
  typedef logic signed [35:0] pid_t;       // PID sum after scaling, Q27.8
  typedef logic [3:0]         cfg_idx_t;
  typedef logic [29:0]        cfg_data_t;

  // Register indexes
  localparam cfg_idx_t REG_GAIN_PROP   = 4'd0;
  localparam cfg_idx_t REG_GAIN_INTEG  = 4'd1;
  localparam cfg_idx_t REG_GAIN_DERIV  = 4'd2;
  localparam cfg_idx_t REG_INTEG_UPPER = 4'd3;
  localparam cfg_idx_t REG_INTEG_LOWER = 4'd4;
  localparam cfg_idx_t REG_DEAD_BAND   = 4'd5;
  localparam cfg_idx_t REG_DRIVE_LIMIT = 4'd6;
  localparam cfg_idx_t REG_SLEW_STEP   = 4'd7;

  // Register reset values
  localparam gain_t RST_GAIN_PROP   = 30'd655360;
  localparam gain_t RST_GAIN_INTEG  = 30'd2294;
  localparam gain_t RST_GAIN_DERIV  = 30'd655360000;
  localparam esum_t RST_INTEG_UPPER = 21'sd532480;
  localparam esum_t RST_INTEG_LOWER = -21'sd532480;
  localparam ulim_t RST_DEAD_BAND   = 15'd73;
  localparam ulim_t RST_DRIVE_LIMIT = 15'd25600;
  localparam ulim_t RST_SLEW_STEP   = 15'd128;

  // Q.26 -> Q7.8 scaling, round half up
  localparam int   SCALE_SHIFT = 18;
  localparam acc_t ROUND_HALF  = acc_t'(1) <<< (SCALE_SHIFT - 1);

endpackage

>>> sv/hpdd_ifs.sv
interface hpdd_in_if;
  logic               valid;
  logic               ready;
  hpdd_pkg::heading_t target_heading;
  hpdd_pkg::heading_t measured_heading;

  modport source (output valid, output target_heading, output measured_heading,
                  input ready);
  modport sink   (input valid, input target_heading, input measured_heading,
                  output ready);
endinterface

interface hpdd_out_if;
  logic           valid;
  logic           ready;
  hpdd_pkg::mag_t left_magnitude;
  logic           left_reverse;
  logic           left_update;
  hpdd_pkg::mag_t right_magnitude;
  logic           right_reverse;
  logic           right_update;

  modport source (output valid, output left_magnitude, output left_reverse,
                  output left_update, output right_magnitude, output right_reverse,
                  output right_update, input ready);
  modport sink   (input valid, input left_magnitude, input left_reverse,
                  input left_update, input right_magnitude, input right_reverse,
                  input right_update, output ready);
endinterface

interface hpdd_cfg_if;
  logic                valid;
  logic                ready;
  hpdd_pkg::cfg_idx_t  index;
  hpdd_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/heading_pid_differential_drive.sv
// Channel   Interface     Dir  Fields
// in_item   hpdd_in_if    in   target_heading, measured_heading
// out_item  hpdd_out_if   out  left/right magnitude, reverse, update
// cfg_wr    hpdd_cfg_if   in   index (0..7 used, others ignored), data
//
// One item per cycle sustained while out_item.ready keeps up; a result passes
// through the error stage, error-sum/derivative stage, multiply stage, add stage,
// scale/clamp stage and slew/output stage after its item is accepted.
// rst_n is synchronous, active low; it restores the register defaults and
// clears error sum, last error and both kept drives.
// The whole pipeline advances together: when a result sits in the output
// register and out_item.ready is low, in_item.ready drops and every stage holds.
// cfg_wr.ready is always high.
module heading_pid_differential_drive (
  input  logic       clk,
  input  logic       rst_n,
  hpdd_in_if.sink    in_item,
  hpdd_out_if.source out_item,
  hpdd_cfg_if.sink   cfg_wr
);

  // ---------------------------------------------------------------- config
  hpdd_pkg::gain_t gain_prop_r, gain_integ_r, gain_deriv_r;
  hpdd_pkg::esum_t integ_upper_r, integ_lower_r;
  hpdd_pkg::ulim_t dead_band_r, drive_limit_r, slew_step_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= hpdd_pkg::RST_GAIN_PROP;
      gain_integ_r  <= hpdd_pkg::RST_GAIN_INTEG;
      gain_deriv_r  <= hpdd_pkg::RST_GAIN_DERIV;
      integ_upper_r <= hpdd_pkg::RST_INTEG_UPPER;
      integ_lower_r <= hpdd_pkg::RST_INTEG_LOWER;
      dead_band_r   <= hpdd_pkg::RST_DEAD_BAND;
      drive_limit_r <= hpdd_pkg::RST_DRIVE_LIMIT;
      slew_step_r   <= hpdd_pkg::RST_SLEW_STEP;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        hpdd_pkg::REG_GAIN_PROP:   gain_prop_r   <= cfg_wr.data[29:0];
        hpdd_pkg::REG_GAIN_INTEG:  gain_integ_r  <= cfg_wr.data[29:0];
        hpdd_pkg::REG_GAIN_DERIV:  gain_deriv_r  <= cfg_wr.data[29:0];
        hpdd_pkg::REG_INTEG_UPPER: integ_upper_r <= $signed(cfg_wr.data[20:0]);
        hpdd_pkg::REG_INTEG_LOWER: integ_lower_r <= $signed(cfg_wr.data[20:0]);
        hpdd_pkg::REG_DEAD_BAND:   dead_band_r   <= cfg_wr.data[14:0];
        hpdd_pkg::REG_DRIVE_LIMIT: drive_limit_r <= cfg_wr.data[14:0];
        hpdd_pkg::REG_SLEW_STEP:   slew_step_r   <= cfg_wr.data[14:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- pipeline control
  logic out_valid_r;
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic adv;

  // Everything moves when the output register is empty or being drained.
  assign adv           = !out_valid_r || out_item.ready;
  assign in_item.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_item.valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // ------------------------------------------------- stage 0: heading error
  hpdd_pkg::err_t err0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      err0_r <= hpdd_pkg::err_t'(in_item.target_heading)
              - hpdd_pkg::err_t'(in_item.measured_heading);
    end
  end

  // ---------------------------------- stage 1: error sum, derivative, deadband
  hpdd_pkg::esum_t      error_sum_r, sum_nxt;
  hpdd_pkg::err_t       last_error_r;
  hpdd_pkg::esum_wide_t sum_wide;
  hpdd_pkg::deriv_t     deriv_nxt;
  logic [16:0]          abs_err;
  logic                 active_nxt;

  hpdd_pkg::err_t   err1_r;
  hpdd_pkg::esum_t  sum1_r;
  hpdd_pkg::deriv_t deriv1_r;
  logic             active1_r;

  always_comb begin
    sum_wide = hpdd_pkg::esum_wide_t'(error_sum_r) + hpdd_pkg::esum_wide_t'(err0_r);
    // upper bound wins when the bounds are crossed
    priority if (sum_wide > hpdd_pkg::esum_wide_t'(integ_upper_r)) begin
      sum_nxt = integ_upper_r;
    end else if (sum_wide < hpdd_pkg::esum_wide_t'(integ_lower_r)) begin
      sum_nxt = integ_lower_r;
    end else begin
      sum_nxt = sum_wide[20:0];
    end
    deriv_nxt  = hpdd_pkg::deriv_t'(err0_r) - hpdd_pkg::deriv_t'(last_error_r);
    abs_err    = err0_r[16] ? 17'(-err0_r) : 17'(err0_r);
    active_nxt = abs_err > {2'b00, dead_band_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (adv && v0_r) begin
      error_sum_r  <= sum_nxt;
      last_error_r <= err0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err1_r    <= err0_r;
      sum1_r    <= sum_nxt;
      deriv1_r  <= deriv_nxt;
      active1_r <= active_nxt;
    end
  end

  // ------------------------------------------------------ stage 2: products
  hpdd_pkg::prod_p_t p_prop2_r;
  hpdd_pkg::prod_i_t p_int2_r;
  hpdd_pkg::prod_d_t p_der2_r;
  logic              active2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_prop2_r <= $signed({1'b0, gain_prop_r}) * err1_r;
      p_int2_r  <= $signed({1'b0, gain_integ_r}) * sum1_r;
      p_der2_r  <= $signed({1'b0, gain_deriv_r}) * deriv1_r;
      active2_r <= active1_r;
    end
  end

  // ------------------------------------------------------ stage 3: PID sum
  hpdd_pkg::acc_t acc3_r;
  logic           active3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc3_r    <= hpdd_pkg::acc_t'(p_prop2_r) + hpdd_pkg::acc_t'(p_int2_r)
                 + hpdd_pkg::acc_t'(p_der2_r) + hpdd_pkg::ROUND_HALF;
      active3_r <= active2_r;
    end
  end

  // ------------------------------------------- stage 4: scale and saturate
  hpdd_pkg::pid_t   pid_scaled, lim_pos, lim_neg;
  hpdd_pkg::drive_t tgt_nxt;
  hpdd_pkg::drive_t tgt4_r;
  logic             active4_r;

  always_comb begin
    // arithmetic shift of the rounded sum = floor, matching round half up
    pid_scaled = hpdd_pkg::pid_t'(acc3_r >>> hpdd_pkg::SCALE_SHIFT);
    lim_pos    = hpdd_pkg::pid_t'({1'b0, drive_limit_r});
    lim_neg    = -lim_pos;
    priority if (pid_scaled > lim_pos) begin
      tgt_nxt = hpdd_pkg::drive_t'(lim_pos);
    end else if (pid_scaled < lim_neg) begin
      tgt_nxt = hpdd_pkg::drive_t'(lim_neg);
    end else begin
      tgt_nxt = hpdd_pkg::drive_t'(pid_scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tgt4_r    <= tgt_nxt;
      active4_r <= active3_r;
    end
  end

  // ------------------------------------------- stage 5: slew and output
  hpdd_pkg::drive_t left_drive_r, right_drive_r;
  hpdd_pkg::drive_t left_nxt, right_nxt;
  logic             lu, ru;
  hpdd_pkg::drive_t left_abs, right_abs;

  // Move one step toward the target; hold when that step would pass it.
  function automatic hpdd_pkg::drive_t slew_to(hpdd_pkg::drive_t cur,
                                               hpdd_pkg::drive_t tgt,
                                               hpdd_pkg::ulim_t step);
    hpdd_pkg::drive_wide_t c, t, up, dn;
    hpdd_pkg::drive_t      res;
    c  = hpdd_pkg::drive_wide_t'(cur);
    t  = hpdd_pkg::drive_wide_t'(tgt);
    up = c + $signed({3'b000, step});
    dn = c - $signed({3'b000, step});
    priority if (c < t && up <= t) begin
      res = up[15:0];
    end else if (c > t && dn >= t) begin
      res = dn[15:0];
    end else begin
      res = cur;
    end
    return res;
  endfunction

  always_comb begin
    left_nxt  = slew_to(left_drive_r, tgt4_r, slew_step_r);
    right_nxt = slew_to(right_drive_r, -tgt4_r, slew_step_r);
    lu        = active4_r && (left_nxt != '0);
    ru        = active4_r && (right_nxt != '0);
    left_abs  = left_nxt[15] ? -left_nxt : left_nxt;
    right_abs = right_nxt[15] ? -right_nxt : right_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_drive_r  <= '0;
      right_drive_r <= '0;
    end else if (adv && v4_r && active4_r) begin
      left_drive_r  <= left_nxt;
      right_drive_r <= right_nxt;
    end
  end

  hpdd_pkg::mag_t left_mag_r, right_mag_r;
  logic           left_rev_r, right_rev_r, left_upd_r, right_upd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      left_mag_r  <= lu ? left_abs[14:0] : '0;
      left_rev_r  <= lu && left_nxt[15];
      left_upd_r  <= lu;
      right_mag_r <= ru ? right_abs[14:0] : '0;
      right_rev_r <= ru && right_nxt[15];
      right_upd_r <= ru;
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.left_magnitude  = left_mag_r;
  assign out_item.left_reverse    = left_rev_r;
  assign out_item.left_update     = left_upd_r;
  assign out_item.right_magnitude = right_mag_r;
  assign out_item.right_reverse   = right_rev_r;
  assign out_item.right_update    = right_upd_r;

  // ------------------------------------------------------------ assertions
  // targets are mirrored and slew is symmetric, so the wheels stay mirrored
  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    right_drive_r == -left_drive_r)
    else $error("wheel drives not mirrored");

  // a kept drive changes by exactly one slew step, and only for an item
  a_slew_step: assert property (@(posedge clk) disable iff (!rst_n)
    (left_drive_r != $past(left_drive_r)) |->
      ($past(adv && v4_r && active4_r) &&
       ((left_drive_r - $past(left_drive_r) == hpdd_pkg::drive_t'($past(slew_step_r))) ||
        ($past(left_drive_r) - left_drive_r == hpdd_pkg::drive_t'($past(slew_step_r))))))
    else $error("drive moved by other than one slew step");

  // no command means no magnitude or direction
  a_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !left_upd_r) |-> (left_mag_r == '0 && !left_rev_r))
    else $error("left fields set without update");

  // an issued command never carries zero drive
  a_cmd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && right_upd_r) |-> (right_mag_r != '0))
    else $error("right update with zero drive");

endmodule
